### rtl/core/bhpc_pkg.sv
// Shared types, constants and helper functions for the Hermite profile coefficient block.
`timescale 1ns / 1ps

package bhpc_pkg;

    localparam int PROFILE_PARAMS = 6;
    localparam int SEGMENT_COUNT  = 4;
    localparam int KNOT_COUNT     = SEGMENT_COUNT + 1;
    localparam int PIDX_W         = $clog2(PROFILE_PARAMS);
    localparam int SIDX_W         = $clog2(SEGMENT_COUNT);
    localparam int KIDX_W         = $clog2(KNOT_COUNT);

    // output transaction payload width, padded to whole bytes
    localparam int OUT_BITS   = 132;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef logic signed [15:0] q88_t;
    typedef logic signed [18:0] knot_t;

    // opcodes
    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_START   = 2'd1;
    localparam logic [1:0] OP_RECOMP  = 2'd2;

    // configuration register indexes
    localparam logic [2:0] IDX_DURATION = 3'd6;

    // profile value slots
    localparam logic [PIDX_W-1:0] P_EXT_TORQUE  = 3'd0;
    localparam logic [PIDX_W-1:0] P_FLEX_TORQUE = 3'd1;
    localparam logic [PIDX_W-1:0] P_EXT_TIME    = 3'd2;
    localparam logic [PIDX_W-1:0] P_FLEX_TIME   = 3'd3;
    localparam logic [PIDX_W-1:0] P_MID_TIME    = 3'd4;
    localparam logic [PIDX_W-1:0] P_RISE_TIME   = 3'd5;

    // divider operand selection
    localparam logic [1:0] DIVS_BLEND = 2'd0;
    localparam logic [1:0] DIVS_QUAD  = 2'd1;
    localparam logic [1:0] DIVS_CUBE  = 2'd2;

    localparam knot_t      HUNDRED_Q8     = 19'sd25600;
    localparam logic [15:0] DURATION_RESET = 16'd5000;

    typedef struct packed {
        logic              load_in;
        logic              snap;
        logic              take_targets;
        logic              mul_blend;
        logic [PIDX_W-1:0] param_idx;
        logic              div_start;
        logic [1:0]        div_sel;
        logic              blend_write;
        logic              seg_load;
        logic [SIDX_W-1:0] seg_idx;
        logic              mul_sq;
        logic              mul_cube;
        logic              quad_write;
        logic              cube_write;
        logic              out_load;
    } bhpc_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       blending;
        logic       blend_over;
        logic       div_done;
        logic       h_zero;
    } bhpc_status_t;

    // profile values after reset, Q8.8
    function automatic q88_t init_profile(input logic [PIDX_W-1:0] idx);
        q88_t v;
        case (idx)
            P_EXT_TORQUE:  v = -16'sd3072;
            P_FLEX_TORQUE: v = 16'sd2048;
            P_EXT_TIME:    v = 16'sd5120;
            P_FLEX_TIME:   v = 16'sd18432;
            P_MID_TIME:    v = 16'sd9728;
            P_RISE_TIME:   v = 16'sd6400;
            default:       v = 16'sd0;
        endcase
        return v;
    endfunction

    // apply sign to a rounded quotient and clamp to signed 32 bits
    function automatic logic [31:0] sat_coef(input logic [32:0] q, input logic ovf,
                                             input logic neg);
        logic [31:0] r;
        if (neg) begin
            if (ovf || q > 33'h080000000)
                r = 32'h8000_0000;
            else
                r = 32'd0 - q[31:0];
        end
        else begin
            if (ovf || q > 33'h07FFFFFFF)
                r = 32'h7FFF_FFFF;
            else
                r = q[31:0];
        end
        return r;
    endfunction

endpackage

### rtl/core/blended_hermite_profile_coefficients.sv
// Top level: blended Hermite torque profile, power-form segment coefficients.
`timescale 1ns / 1ps

// Usage
//  Slave stream: one transaction per command. tuser carries the opcode (tick and
//  blend, start blend, recompute), tdata the current time in ms.
//  Master stream: four transactions per tick (while blending) or recompute, one
//  per spline segment, tlast on segment 3. Start blend and idle ticks give none.
//  Config port: cfg_we/cfg_index/cfg_data write the six blend targets and the
//  blend duration; only write while the block is idle.
//  Timing: the shared restoring divider gives one quotient bit a cycle. Recompute
//  steps through each segment in turn (load, h^2, h^3, two divisions, hand-off);
//  a zero-width segment goes from h^2 straight to hand-off. A blending tick
//  first updates each of the six profile values with a multiply and a division.
//  A tick that finishes the blend skips that part.
//  One command is processed at a time; s_tready is high only when idle. The
//  result register lets the next command be accepted while the last segment
//  still waits on the master side.
//  Stall: a held master side stops the sequencer before loading the next
//  segment; nothing is dropped.
//  Reset: asynchronous, active low. Profile returns to its initial values,
//  targets to zero, duration to 5000 ms, blend inactive.

module blended_hermite_profile_coefficients (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [31:0]                       s_tdata,   // [31:0] current_time_ms
    input  logic [1:0]                        s_tuser,   // [1:0] opcode
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [1:0] segment_index, [17:2] knot_start, [33:18] coef_constant,
    // [65:34] coef_linear, [97:66] coef_quadratic, [129:98] coef_cubic,
    // [130] width_fault, [131] still_blending, rest zero
    output logic [bhpc_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic                              m_tlast,   // last_segment
    input  logic                              cfg_we,
    input  logic [2:0]                        cfg_index,
    input  logic [15:0]                       cfg_data
);

    bhpc_pkg::bhpc_cmd_t    cmd;
    bhpc_pkg::bhpc_status_t status;

    bhpc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bhpc_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_time   (s_tdata),
        .in_op     (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_data  (m_tdata),
        .out_last  (m_tlast)
    );

    // an accepted command takes the sequencer out of idle, so s_tready drops
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted on consecutive cycles");

    // a segment result is only loaded into a free output register
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("output register overwritten");

    // landing on the targets ends the blend
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take_targets |=> !status.blending)
        else $error("blend still active after taking targets");

endmodule

### rtl/core/bhpc_div.sv
// Restoring divider, one quotient bit per cycle, 33-bit quotient with overflow flag.
`timescale 1ns / 1ps

module bhpc_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] num,
    input  logic [63:0] den,
    output logic [32:0] quot,
    output logic        ovf,
    output logic        done
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [64:0] rem_reg, rem_next;
    logic [32:0] nsh_reg, nsh_next;
    logic [32:0] q_reg, q_next;
    logic [63:0] den_reg, den_next;
    logic        ovf_reg, ovf_next;
    logic [64:0] rem_sh;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        nsh_next  = nsh_reg;
        q_next    = q_reg;
        den_next  = den_reg;
        ovf_next  = ovf_reg;
        rem_sh    = {rem_reg[63:0], nsh_reg[32]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 6'd33;
            rem_next  = {34'd0, num[63:33]};
            nsh_next  = num[32:0];
            q_next    = 33'd0;
            den_next  = den;
            // quotient of 2^33 or more: top bits already reach the divisor
            ovf_next  = ({33'd0, num[63:33]} >= den);
        end
        else if (busy_reg)
        begin
            nsh_next = {nsh_reg[31:0], 1'b0};
            if (rem_sh >= {1'b0, den_reg})
            begin
                rem_next = rem_sh - {1'b0, den_reg};
                q_next   = {q_reg[31:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                q_next   = {q_reg[31:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        nsh_reg <= nsh_next;
        q_reg   <= q_next;
        den_reg <= den_next;
        ovf_reg <= ovf_next;
    end

    assign quot = q_reg;
    assign ovf  = ovf_reg;
    assign done = done_reg;

endmodule

### rtl/core/bhpc_datapath.sv
// Datapath: profile and blend state, knots, shared multiplier, divider and result register.
`timescale 1ns / 1ps

module bhpc_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  bhpc_pkg::bhpc_cmd_t                 cmd,
    output bhpc_pkg::bhpc_status_t              status,
    input  logic [31:0]                         in_time,
    input  logic [1:0]                          in_op,
    input  logic                                cfg_we,
    input  logic [2:0]                          cfg_index,
    input  logic [15:0]                         cfg_data,
    output logic [bhpc_pkg::OUT_DATA_W-1:0]     out_data,
    output logic                                out_last
);

    bhpc_pkg::q88_t profile_reg [bhpc_pkg::PROFILE_PARAMS];
    bhpc_pkg::q88_t start_reg   [bhpc_pkg::PROFILE_PARAMS];
    bhpc_pkg::q88_t target_reg  [bhpc_pkg::PROFILE_PARAMS];
    logic [15:0]    dur_reg;
    logic [31:0]    start_time_reg;
    logic           blending_reg;

    logic [1:0]     op_reg;
    logic [31:0]    time_reg;
    logic [31:0]    elapsed_reg;

    // blend operands
    logic [32:0]    mag_reg;
    logic           bl_neg_reg;
    logic signed [16:0] diff;
    logic [16:0]    adiff;
    logic signed [17:0] blend_val;
    logic signed [17:0] q_signed;

    // segment operands
    bhpc_pkg::knot_t knot_x [bhpc_pkg::KNOT_COUNT];
    bhpc_pkg::knot_t knot_y [bhpc_pkg::KNOT_COUNT];
    bhpc_pkg::knot_t x_lo, x_hi, y_lo, y_hi, h, df, ah_full, adf_full;
    logic [16:0]    ah_reg;
    logic [15:0]    adf_reg;
    logic           quad_neg_reg, cube_neg_reg, hzero_reg;
    logic [15:0]    knot_reg, const_reg;
    logic [33:0]    hsq_reg;
    logic [50:0]    hcub_reg;
    logic [31:0]    c2_reg, c3_reg;
    logic [15:0]    knot_sat;
    logic [16:0]    adf3;

    // shared multiplier
    logic [33:0]    mul_a;
    logic [16:0]    mul_b;
    logic [50:0]    prod;

    // divider
    logic [63:0]    div_num, div_den;
    logic [32:0]    div_q;
    logic           div_ovf, div_done;

    // result register
    logic [1:0]     o_seg_reg;
    logic [15:0]    o_knot_reg, o_const_reg;
    logic [31:0]    o_c2_reg, o_c3_reg;
    logic           o_fault_reg, o_blend_reg, o_last_reg;

    // knots from the profile
    always_comb
    begin
        knot_x[0] = 19'(profile_reg[bhpc_pkg::P_EXT_TIME])
                  - 19'(profile_reg[bhpc_pkg::P_RISE_TIME]);
        knot_x[1] = 19'(profile_reg[bhpc_pkg::P_EXT_TIME]);
        knot_x[2] = 19'(profile_reg[bhpc_pkg::P_MID_TIME]);
        knot_x[3] = 19'(profile_reg[bhpc_pkg::P_FLEX_TIME]);
        knot_x[4] = bhpc_pkg::HUNDRED_Q8 - 19'(profile_reg[bhpc_pkg::P_RISE_TIME])
                  + 19'(profile_reg[bhpc_pkg::P_EXT_TIME]);
        knot_y[0] = '0;
        knot_y[1] = 19'(profile_reg[bhpc_pkg::P_EXT_TORQUE]);
        knot_y[2] = '0;
        knot_y[3] = 19'(profile_reg[bhpc_pkg::P_FLEX_TORQUE]);
        knot_y[4] = '0;
    end

    always_comb
    begin
        x_lo     = knot_x[{1'b0, cmd.seg_idx}];
        x_hi     = knot_x[{1'b0, cmd.seg_idx} + 3'd1];
        y_lo     = knot_y[{1'b0, cmd.seg_idx}];
        y_hi     = knot_y[{1'b0, cmd.seg_idx} + 3'd1];
        h        = x_hi - x_lo;
        df       = y_hi - y_lo;
        ah_full  = h[18] ? -h : h;
        adf_full = df[18] ? -df : df;
        if (x_lo > 19'sd32767)
            knot_sat = 16'h7FFF;
        else if (x_lo < -19'sd32768)
            knot_sat = 16'h8000;
        else
            knot_sat = x_lo[15:0];
    end

    // blend operands for the selected parameter
    always_comb
    begin
        diff  = 17'(target_reg[cmd.param_idx]) - 17'(start_reg[cmd.param_idx]);
        adiff = diff[16] ? 17'(-diff) : 17'(diff);
        q_signed  = bl_neg_reg ? -$signed({1'b0, div_q[16:0]})
                               : $signed({1'b0, div_q[16:0]});
        blend_val = 18'(start_reg[cmd.param_idx]) + q_signed;
    end

    // one multiplier shared by blend scaling, h^2 and h^3
    always_comb
    begin
        if (cmd.mul_blend)
        begin
            mul_a = {17'd0, adiff};
            mul_b = {1'b0, elapsed_reg[15:0]};
        end
        else if (cmd.mul_cube)
        begin
            mul_a = hsq_reg;
            mul_b = ah_reg;
        end
        else
        begin
            mul_a = {17'd0, ah_reg};
            mul_b = ah_reg;
        end
        prod = 51'(mul_a) * 51'(mul_b);
    end

    // rounded division: (2*num + den) / (2*den)
    assign adf3 = {1'b0, adf_reg} + {adf_reg, 1'b0};

    always_comb
    begin
        case (cmd.div_sel)
            bhpc_pkg::DIVS_QUAD:
            begin
                div_num = ({47'd0, adf3} << 33) + {30'd0, hsq_reg};
                div_den = {29'd0, hsq_reg, 1'b0};
            end
            bhpc_pkg::DIVS_CUBE:
            begin
                div_num = ({48'd0, adf_reg} << 42) + {13'd0, hcub_reg};
                div_den = {12'd0, hcub_reg, 1'b0};
            end
            default:
            begin
                div_num = {30'd0, mag_reg, 1'b0} + {48'd0, dur_reg};
                div_den = {47'd0, dur_reg, 1'b0};
            end
        endcase
    end

    bhpc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .quot  (div_q),
        .ovf   (div_ovf),
        .done  (div_done)
    );

    // profile, targets and blend state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < bhpc_pkg::PROFILE_PARAMS; i++)
            begin
                profile_reg[i] <= bhpc_pkg::init_profile(bhpc_pkg::PIDX_W'(i));
                start_reg[i]   <= '0;
                target_reg[i]  <= '0;
            end
            dur_reg        <= bhpc_pkg::DURATION_RESET;
            start_time_reg <= '0;
            blending_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index < bhpc_pkg::IDX_DURATION)
                    target_reg[cfg_index] <= cfg_data;
                else if (cfg_index == bhpc_pkg::IDX_DURATION)
                    dur_reg <= cfg_data;
            end
            if (cmd.snap)
            begin
                for (int i = 0; i < bhpc_pkg::PROFILE_PARAMS; i++)
                    start_reg[i] <= profile_reg[i];
                start_time_reg <= time_reg;
                blending_reg   <= 1'b1;
            end
            if (cmd.take_targets)
            begin
                for (int i = 0; i < bhpc_pkg::PROFILE_PARAMS; i++)
                    profile_reg[i] <= target_reg[i];
                blending_reg <= 1'b0;
            end
            if (cmd.blend_write)
                profile_reg[cmd.param_idx] <= blend_val[15:0];
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg      <= in_op;
            time_reg    <= in_time;
            elapsed_reg <= in_time - start_time_reg;
        end
        if (cmd.mul_blend)
        begin
            mag_reg    <= prod[32:0];
            bl_neg_reg <= diff[16];
        end
        if (cmd.seg_load)
        begin
            ah_reg       <= ah_full[16:0];
            adf_reg      <= adf_full[15:0];
            quad_neg_reg <= df[18];
            cube_neg_reg <= ((df > 0) == (h > 0));
            hzero_reg    <= (h == 0);
            knot_reg     <= knot_sat;
            const_reg    <= y_lo[15:0];
            c2_reg       <= '0;
            c3_reg       <= '0;
        end
        if (cmd.mul_sq)
            hsq_reg <= prod[33:0];
        if (cmd.mul_cube)
            hcub_reg <= prod;
        if (cmd.quad_write)
            c2_reg <= bhpc_pkg::sat_coef(div_q, div_ovf, quad_neg_reg);
        if (cmd.cube_write)
            c3_reg <= bhpc_pkg::sat_coef(div_q, div_ovf, cube_neg_reg);
        if (cmd.out_load)
        begin
            o_seg_reg   <= cmd.seg_idx;
            o_knot_reg  <= knot_reg;
            o_const_reg <= const_reg;
            o_c2_reg    <= c2_reg;
            o_c3_reg    <= c3_reg;
            o_fault_reg <= hzero_reg;
            o_blend_reg <= blending_reg;
            o_last_reg  <= (cmd.seg_idx == bhpc_pkg::SIDX_W'(bhpc_pkg::SEGMENT_COUNT - 1));
        end
    end

    assign status.op         = op_reg;
    assign status.blending   = blending_reg;
    assign status.blend_over = (elapsed_reg >= {16'd0, dur_reg});
    assign status.div_done   = div_done;
    assign status.h_zero     = hzero_reg;

    assign out_data = {(bhpc_pkg::OUT_DATA_W - bhpc_pkg::OUT_BITS)'(0),
                       o_blend_reg, o_fault_reg, o_c3_reg, o_c2_reg, 32'd0,
                       o_const_reg, o_knot_reg, o_seg_reg};
    assign out_last = o_last_reg;

endmodule

### rtl/core/bhpc_ctrl.sv
// Controller: sequences blend steps, segment computations and result hand-off.
`timescale 1ns / 1ps

module bhpc_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    input  bhpc_pkg::bhpc_status_t status,
    output bhpc_pkg::bhpc_cmd_t    cmd
);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_DECODE   = 4'd1;
    localparam logic [3:0] ST_BL_MUL   = 4'd2;
    localparam logic [3:0] ST_BL_DIV   = 4'd3;
    localparam logic [3:0] ST_BL_WAIT  = 4'd4;
    localparam logic [3:0] ST_SEG_LOAD = 4'd5;
    localparam logic [3:0] ST_SEG_SQ   = 4'd6;
    localparam logic [3:0] ST_SEG_CUBE = 4'd7;
    localparam logic [3:0] ST_DIV_Q    = 4'd8;
    localparam logic [3:0] ST_WAIT_Q   = 4'd9;
    localparam logic [3:0] ST_DIV_C    = 4'd10;
    localparam logic [3:0] ST_WAIT_C   = 4'd11;
    localparam logic [3:0] ST_SEG_OUT  = 4'd12;

    logic [3:0]                  state_reg, state_next;
    logic [bhpc_pkg::PIDX_W-1:0] pidx_reg, pidx_next;
    logic [bhpc_pkg::SIDX_W-1:0] sidx_reg, sidx_next;
    logic                        mvalid_reg, mvalid_next;
    logic                        slot_free;

    assign slot_free = !mvalid_reg || m_tready;

    always_comb
    begin
        state_next    = state_reg;
        pidx_next     = pidx_reg;
        sidx_next     = sidx_reg;
        mvalid_next   = mvalid_reg && !m_tready;
        cmd           = '0;
        cmd.param_idx = pidx_reg;
        cmd.seg_idx   = sidx_reg;
        cmd.div_sel   = bhpc_pkg::DIVS_BLEND;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                sidx_next = '0;
                pidx_next = '0;
                if (status.op == bhpc_pkg::OP_START)
                begin
                    cmd.snap   = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (status.op == bhpc_pkg::OP_RECOMP)
                    state_next = ST_SEG_LOAD;
                else if (status.op == bhpc_pkg::OP_TICK && status.blending)
                begin
                    if (status.blend_over)
                    begin
                        cmd.take_targets = 1'b1;
                        state_next       = ST_SEG_LOAD;
                    end
                    else
                        state_next = ST_BL_MUL;
                end
                else
                    state_next = ST_IDLE;
            end
            ST_BL_MUL:
            begin
                cmd.mul_blend = 1'b1;
                state_next    = ST_BL_DIV;
            end
            ST_BL_DIV:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_BL_WAIT;
            end
            ST_BL_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.blend_write = 1'b1;
                    if (pidx_reg == bhpc_pkg::PIDX_W'(bhpc_pkg::PROFILE_PARAMS - 1))
                        state_next = ST_SEG_LOAD;
                    else
                    begin
                        pidx_next  = pidx_reg + bhpc_pkg::PIDX_W'(1);
                        state_next = ST_BL_MUL;
                    end
                end
            end
            ST_SEG_LOAD:
            begin
                cmd.seg_load = 1'b1;
                state_next   = ST_SEG_SQ;
            end
            ST_SEG_SQ:
            begin
                cmd.mul_sq = 1'b1;
                state_next = status.h_zero ? ST_SEG_OUT : ST_SEG_CUBE;
            end
            ST_SEG_CUBE:
            begin
                cmd.mul_cube = 1'b1;
                state_next   = ST_DIV_Q;
            end
            ST_DIV_Q:
            begin
                cmd.div_sel   = bhpc_pkg::DIVS_QUAD;
                cmd.div_start = 1'b1;
                state_next    = ST_WAIT_Q;
            end
            ST_WAIT_Q:
            begin
                if (status.div_done)
                begin
                    cmd.quad_write = 1'b1;
                    state_next     = ST_DIV_C;
                end
            end
            ST_DIV_C:
            begin
                cmd.div_sel   = bhpc_pkg::DIVS_CUBE;
                cmd.div_start = 1'b1;
                state_next    = ST_WAIT_C;
            end
            ST_WAIT_C:
            begin
                if (status.div_done)
                begin
                    cmd.cube_write = 1'b1;
                    state_next     = ST_SEG_OUT;
                end
            end
            ST_SEG_OUT:
            begin
                if (slot_free)
                begin
                    cmd.out_load = 1'b1;
                    mvalid_next  = 1'b1;
                    if (sidx_reg == bhpc_pkg::SIDX_W'(bhpc_pkg::SEGMENT_COUNT - 1))
                        state_next = ST_IDLE;
                    else
                    begin
                        sidx_next  = sidx_reg + bhpc_pkg::SIDX_W'(1);
                        state_next = ST_SEG_LOAD;
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            pidx_reg   <= '0;
            sidx_reg   <= '0;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pidx_reg   <= pidx_next;
            sidx_reg   <= sidx_next;
            mvalid_reg <= mvalid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mvalid_reg;

endmodule

### verif/testbench.sv
// Self-checking testbench for the blended Hermite profile coefficient block.
`timescale 1ns / 1ps

module testbench;

    // opcode that the block must ignore
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // configuration register indexes
    localparam logic [2:0] IDX_EXT_TORQUE = 3'd0;
    localparam logic [2:0] IDX_FLEX_TORQUE = 3'd1;
    localparam logic [2:0] IDX_EXT_TIME = 3'd2;
    localparam logic [2:0] IDX_FLEX_TIME = 3'd3;
    localparam logic [2:0] IDX_MID_TIME = 3'd4;
    localparam logic [2:0] IDX_RISE_TIME = 3'd5;

    // cycles allowed for a command that gives no transaction to finish
    localparam int DRAIN_CYCLES = 800;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_ITEMS = 104;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [31:0] s_tdata;
    logic [1:0] s_tuser;
    logic m_tvalid;
    logic m_tready;
    logic [bhpc_pkg::OUT_DATA_W-1:0] m_tdata;
    logic m_tlast;
    logic cfg_we;
    logic [2:0] cfg_index;
    logic [15:0] cfg_data;

    blended_hermite_profile_coefficients dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // one segment transaction as the block should produce it
    typedef struct {
        bit [1:0] seg;
        bit [15:0] knot;
        bit [15:0] c0;
        bit [31:0] c1;
        bit [31:0] c2;
        bit [31:0] c3;
        bit fault;
        bit blend;
        bit last;
    } segment_t;

    // directed row: either a command or a register write
    typedef struct {
        bit is_cfg;
        bit [2:0] code;
        bit [31:0] val;
        bit pin;
        bit [15:0] pin_knot;
    } row_t;

    segment_t segment_q[$];
    row_t directed_rows[$];

    // shadow of the block's state
    int profile[bhpc_pkg::PROFILE_PARAMS];
    int snap_vals[bhpc_pkg::PROFILE_PARAMS];
    int targets[bhpc_pkg::PROFILE_PARAMS];
    bit [15:0] duration;
    bit [31:0] snap_time;
    bit blending;

    int mismatches;
    int cycles;
    int burst_left;
    int stall_mode;
    bit [31:0] clock_ms;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic bit [31:0] round_coef(bit [63:0] num, bit [63:0] den, bit neg);
        bit [63:0] q;
        q = (num * 2 + den) / (den * 2);
        if (neg)
        begin
            if (q > 64'h8000_0000)
                q = 64'h8000_0000;
            return 32'd0 - q[31:0];
        end
        if (q > 64'h7FFF_FFFF)
            q = 64'h7FFF_FFFF;
        return q[31:0];
    endfunction

    function automatic bit [15:0] clamp16(int v);
        if (v > 32767)
            return 16'h7FFF;
        if (v < -32768)
            return 16'h8000;
        return v[15:0];
    endfunction

    // five knots from the profile, four segments out
    function automatic void predict_segments();
        int x[bhpc_pkg::SEGMENT_COUNT + 1];
        int y[bhpc_pkg::SEGMENT_COUNT + 1];
        longint h;
        longint df;
        bit [63:0] ah;
        bit [63:0] adf;
        segment_t s;
        x[0] = profile[bhpc_pkg::P_EXT_TIME] - profile[bhpc_pkg::P_RISE_TIME];
        x[1] = profile[bhpc_pkg::P_EXT_TIME];
        x[2] = profile[bhpc_pkg::P_MID_TIME];
        x[3] = profile[bhpc_pkg::P_FLEX_TIME];
        x[4] = 25600 - profile[bhpc_pkg::P_RISE_TIME] + profile[bhpc_pkg::P_EXT_TIME];
        y[0] = 0;
        y[1] = profile[bhpc_pkg::P_EXT_TORQUE];
        y[2] = 0;
        y[3] = profile[bhpc_pkg::P_FLEX_TORQUE];
        y[4] = 0;
        for (int i = 0; i < bhpc_pkg::SEGMENT_COUNT; i++)
        begin
            h = longint'(x[i + 1]) - x[i];
            df = longint'(y[i + 1]) - y[i];
            s.seg = i[1:0];
            s.knot = clamp16(x[i]);
            s.c0 = y[i][15:0];
            s.c1 = '0;
            s.c2 = '0;
            s.c3 = '0;
            s.fault = (h == 0);
            s.blend = blending;
            s.last = (i == bhpc_pkg::SEGMENT_COUNT - 1);
            if (h != 0)
            begin
                ah = (h < 0) ? -h : h;
                adf = (df < 0) ? -df : df;
                s.c2 = round_coef((adf * 3) << 32, ah * ah, df < 0);
                s.c3 = round_coef((adf * 2) << 40, ah * ah * ah, (df > 0) == (h > 0));
            end
            segment_q.push_back(s);
        end
    endfunction

    function automatic void predict_command(bit [1:0] op, bit [31:0] now);
        bit [31:0] elapsed;
        longint diff;
        bit [63:0] q;
        if (op == bhpc_pkg::OP_START)
        begin
            snap_vals = profile;
            snap_time = now;
            blending = 1'b1;
        end
        else if (op == bhpc_pkg::OP_RECOMP)
            predict_segments();
        else if (op == bhpc_pkg::OP_TICK && blending)
        begin
            elapsed = now - snap_time;
            if (elapsed >= {16'd0, duration})
            begin
                profile = targets;
                blending = 1'b0;
            end
            else
            begin
                for (int i = 0; i < bhpc_pkg::PROFILE_PARAMS; i++)
                begin
                    diff = longint'(targets[i]) - snap_vals[i];
                    q = (((diff < 0) ? -diff : diff) * elapsed * 2 + duration)
                        / (64'(duration) * 2);
                    profile[i] = (diff < 0) ? snap_vals[i] - int'(q) : snap_vals[i] + int'(q);
                end
            end
            predict_segments();
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    // send one command; returns at the edge where the transaction took place
    task automatic send_command(bit [1:0] op, bit [31:0] now);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= now;
        do
            @(posedge clk);
        while (!s_tready);
        predict_command(op, now);
    endtask

    // registers only change with nothing in flight
    task automatic write_register(bit [2:0] idx, bit [15:0] val);
        s_tvalid <= 1'b0;
        while (segment_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx < bhpc_pkg::PROFILE_PARAMS)
            targets[idx] = int'($signed(val));
        else
            duration = val;
    endtask

    function automatic void add_cmd(bit [1:0] op, bit [31:0] now, bit pin = 1'b0,
                                    bit [15:0] knot = 16'd0);
        row_t r;
        r.is_cfg = 1'b0;
        r.code = {1'b0, op};
        r.val = now;
        r.pin = pin;
        r.pin_knot = knot;
        directed_rows.push_back(r);
    endfunction

    function automatic void add_cfg(bit [2:0] idx, bit [15:0] val);
        row_t r;
        r.is_cfg = 1'b1;
        r.code = idx;
        r.val = {16'd0, val};
        r.pin = 1'b0;
        r.pin_knot = '0;
        directed_rows.push_back(r);
    endfunction

    function automatic bit [15:0] random_reg_value();
        case ($urandom_range(0, 4))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task automatic check_field(string name, bit [31:0] expected, bit [31:0] actual);
        if (expected !== actual)
        begin
            if (mismatches < 10)
                $display("mismatch %s: expected %h, got %h", name, expected, actual);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        segment_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (segment_q.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected segment transaction: %h", m_tdata);
                mismatches++;
            end
            else
            begin
                e = segment_q.pop_front();
                check_field("segment_index", e.seg, m_tdata[1:0]);
                check_field("knot_start", e.knot, m_tdata[17:2]);
                check_field("coef_constant", e.c0, m_tdata[33:18]);
                check_field("coef_linear", e.c1, m_tdata[65:34]);
                check_field("coef_quadratic", e.c2, m_tdata[97:66]);
                check_field("coef_cubic", e.c3, m_tdata[129:98]);
                check_field("width_fault", e.fault, m_tdata[130]);
                check_field("still_blending", e.blend, m_tdata[131]);
                check_field("last_segment", e.last, m_tlast);
            end
        end
    end

    // receiver back-pressure: always ready, random, or long stalls
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles % 256 == 0)
            stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= (cycles % 32) >= 24;
        endcase
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int sel;
        row_t r;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = bhpc_pkg::OP_TICK;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cycles = 0;
        stall_mode = 0;
        mismatches = 0;
        burst_left = 0;
        for (int i = 0; i < bhpc_pkg::PROFILE_PARAMS; i++)
        begin
            profile[i] = int'(bhpc_pkg::init_profile(bhpc_pkg::PIDX_W'(i)));
            snap_vals[i] = 0;
            targets[i] = 0;
        end
        duration = bhpc_pkg::DURATION_RESET;
        snap_time = '0;
        blending = 1'b0;

        // after reset the first knot sits at ext time - rise time = -5 %
        add_cmd(bhpc_pkg::OP_RECOMP, 32'd0, 1'b1, 16'hFB00);
        add_cmd(bhpc_pkg::OP_TICK, 32'd10);                   // idle tick: nothing out
        add_cmd(OP_UNUSED, 32'hFFFF_FFFF);                    // ignored opcode
        add_cmd(bhpc_pkg::OP_START, 32'd1000);
        add_cmd(bhpc_pkg::OP_TICK, 32'd2000);                 // partway through the blend
        add_cmd(bhpc_pkg::OP_TICK, 32'd500);                  // before the start: wraps, finishes
        add_cmd(bhpc_pkg::OP_RECOMP, 32'd0);                  // all-zero targets: zero widths but for the last segment
        add_cfg(IDX_EXT_TORQUE, 16'h7FFF);
        add_cfg(IDX_FLEX_TORQUE, 16'h8000);
        add_cfg(IDX_EXT_TIME, 16'h7FFF);
        add_cfg(IDX_FLEX_TIME, 16'h8000);
        add_cfg(IDX_MID_TIME, 16'h0000);
        add_cfg(IDX_RISE_TIME, 16'h8000);
        add_cfg(bhpc_pkg::IDX_DURATION, 16'h0000);
        add_cmd(bhpc_pkg::OP_START, 32'd0);
        // zero duration takes the targets at once; first knot saturates high
        add_cmd(bhpc_pkg::OP_TICK, 32'd0, 1'b1, 16'h7FFF);
        add_cfg(bhpc_pkg::IDX_DURATION, 16'hFFFF);
        add_cfg(IDX_EXT_TORQUE, 16'h8000);
        add_cfg(IDX_FLEX_TORQUE, 16'h7FFF);
        add_cfg(IDX_EXT_TIME, 16'h8000);
        add_cfg(IDX_RISE_TIME, 16'h7FFF);
        add_cmd(bhpc_pkg::OP_START, 32'hFFFF_FF00);
        add_cmd(bhpc_pkg::OP_TICK, 32'h0000_0100);            // time wraps through zero
        add_cfg(IDX_MID_TIME, 16'h04D2);                      // new target mid-blend
        add_cmd(bhpc_pkg::OP_TICK, 32'h0000_8000);
        add_cmd(bhpc_pkg::OP_TICK, 32'h7FFF_FFFF);
        add_cfg(bhpc_pkg::IDX_DURATION, 16'h0001);
        add_cmd(bhpc_pkg::OP_START, 32'h1234_5678);
        add_cmd(bhpc_pkg::OP_TICK, 32'h1234_5678);            // no time elapsed
        add_cmd(bhpc_pkg::OP_TICK, 32'h1234_5679);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            r = directed_rows[i];
            if (r.is_cfg)
                write_register(r.code, r.val[15:0]);
            else
            begin
                send_command(r.code[1:0], r.val);
                if (r.pin)
                    segment_q[segment_q.size() - bhpc_pkg::SEGMENT_COUNT].knot = r.pin_knot;
            end
        end

        // random part: mostly blends followed by rising ticks
        write_register(bhpc_pkg::IDX_DURATION, 16'd300);
        clock_ms = $urandom;
        for (int n = 0; n < RANDOM_ITEMS; )
        begin
            sel = $urandom_range(0, 99);
            if (sel < 8)
            begin
                sel = $urandom_range(0, bhpc_pkg::PROFILE_PARAMS);
                if (sel == bhpc_pkg::PROFILE_PARAMS)
                    write_register(bhpc_pkg::IDX_DURATION, ($urandom_range(0, 7) == 0) ?
                                   random_reg_value() : 16'($urandom_range(1, 2000)));
                else
                    write_register(sel[2:0], random_reg_value());
            end
            else if (sel < 22)
            begin
                clock_ms = ($urandom_range(0, 3) == 0) ? $urandom : clock_ms + 1;
                send_command(bhpc_pkg::OP_START, clock_ms);
                n++;
            end
            else if (sel < 32)
            begin
                send_command(bhpc_pkg::OP_RECOMP, $urandom);
                n++;
            end
            else if (sel < 35)
            begin
                send_command(OP_UNUSED, $urandom);
                n++;
            end
            else
            begin
                if ($urandom_range(0, 15) == 0)
                    clock_ms = $urandom;
                else
                    clock_ms = clock_ms + $urandom_range(0, duration / 4 + 1);
                send_command(bhpc_pkg::OP_TICK, clock_ms);
                n++;
            end
        end
        s_tvalid <= 1'b0;

        while (segment_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
